// ===== sv/software_timer_slot_table_assert.svh =====
// ----------------------------------------------------------------------------
// software_timer_slot_table_assert.svh
// Assertion macros shared by the timer slot table RTL.
// ----------------------------------------------------------------------------
`ifndef SOFTWARE_TIMER_SLOT_TABLE_ASSERT_SVH
`define SOFTWARE_TIMER_SLOT_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STT_ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define STT_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== sv/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, codes and defaults of the timer slot table.
// ----------------------------------------------------------------------------
package stt_pkg;

  // Default table size and time counter width.
  localparam int SLOTS_DEF     = 16;
  localparam int TIME_BITS_DEF = 32;
  localparam int ID_W_DEF      = $clog2(SLOTS_DEF + 1);

  // Command codes carried in a command beat.
  typedef enum logic [1:0] {
    CMD_SET  = 2'd0,
    CMD_KILL = 2'd1,
    CMD_PROC = 2'd2
  } cmd_e;

  // Kinds of result beats.
  typedef enum logic [1:0] {
    KIND_SET  = 2'd0,
    KIND_KILL = 2'd1,
    KIND_FIRE = 2'd2,
    KIND_DONE = 2'd3
  } kind_e;

  // Reply status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BAD_ID = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  // Operation of the shared adder.
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  // Static part of one slot entry; the start time is appended in the RAM word.
  typedef struct packed {
    logic [30:0] period;
    logic        rep;
    logic [3:0]  owner;
    logic [7:0]  handler;
    logic [31:0] tag;
  } slot_info_t;

  // One result beat without its id.
  typedef struct packed {
    kind_e       kind;
    status_e     status;
    logic [7:0]  handler;
    logic [31:0] tag;
    logic        last;
  } res_t;

endpackage

// ===== sv/stt_if.sv =====
// ----------------------------------------------------------------------------
// stt_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------

// Command channel.
interface stt_cmd_if
  import stt_pkg::*;
#(
  parameter int ID_W = ID_W_DEF
);
  logic            valid;
  logic            ready;
  logic [1:0]      cmd;
  logic [31:0]     now_time;
  logic [30:0]     period;
  logic            repeating;
  logic [3:0]      owner_id;
  logic [7:0]      handler_id;
  logic [31:0]     user_tag;
  logic [ID_W-1:0] slot_id;

  modport source (
    output valid, cmd, now_time, period, repeating, owner_id, handler_id,
           user_tag, slot_id,
    input  ready
  );
  modport sink (
    input  valid, cmd, now_time, period, repeating, owner_id, handler_id,
           user_tag, slot_id,
    output ready
  );
endinterface

// Result channel.
interface stt_res_if
  import stt_pkg::*;
#(
  parameter int ID_W = ID_W_DEF
);
  logic            valid;
  logic            ready;
  logic [1:0]      kind;
  logic [1:0]      status;
  logic [ID_W-1:0] result_id;
  logic [7:0]      fire_handler;
  logic [31:0]     fire_tag;
  logic            last;

  modport source (
    output valid, kind, status, result_id, fire_handler, fire_tag, last,
    input  ready
  );
  modport sink (
    input  valid, kind, status, result_id, fire_handler, fire_tag, last,
    output ready
  );
endinterface

// ===== sv/stt_ram.sv =====
// ----------------------------------------------------------------------------
// stt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module stt_ram
  import stt_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = SLOTS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/stt_alu.sv =====
// ----------------------------------------------------------------------------
// stt_alu
// Shared adder/subtractor used for elapsed time and for the repeat reload.
// ----------------------------------------------------------------------------
module stt_alu
  import stt_pkg::*;
#(
  parameter int W = TIME_BITS_DEF
) (
  input  alu_op_e      op_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic [W-1:0] y_o
);

  logic sub;

  // Subtraction is addition of the inverted operand plus one; result wraps.
  assign sub = (op_i == ALU_SUB);
  assign y_o = a_i + (b_i ^ {W{sub}}) + W'(sub);

endmodule

// ===== sv/stt_out_reg.sv =====
// ----------------------------------------------------------------------------
// stt_out_reg
// Output register that holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module stt_out_reg
  import stt_pkg::*;
#(
  parameter int ID_W = ID_W_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  res_t            res_i,
  input  logic [ID_W-1:0] id_i,
  output logic            push_ok_o,
  stt_res_if.source       res_o
);

  logic            valid_q;
  res_t            res_q;
  logic [ID_W-1:0] id_q;

  // A new beat may enter when the register is empty or being drained.
  assign push_ok_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (res_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
      id_q  <= id_i;
    end
  end

  assign res_o.valid        = valid_q;
  assign res_o.kind         = res_q.kind;
  assign res_o.status       = res_q.status;
  assign res_o.result_id    = id_q;
  assign res_o.fire_handler = res_q.handler;
  assign res_o.fire_tag     = res_q.tag;
  assign res_o.last         = res_q.last;

endmodule

// ===== sv/software_timer_slot_table.sv =====
// ----------------------------------------------------------------------------
// software_timer_slot_table
// Timer slot table with set, kill and process commands, run by a sequencer
// over one slot RAM and one shared adder.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Beat
//  --------+-----+--------------------------------------------------------
//  cmd_i   | in  | cmd, now_time, period, repeating, owner, handler, tag, id
//  res_o   | out | kind, status, result_id, fire_handler, fire_tag, last
//
//  One command is in work at a time; cmd_i is ready only while idle.
//  Kill checks the slot id and answers; set scans the slots in turn, up
//  to the high-water mark, for a free one. Process visits each slot below
//  the high-water mark: free slots are skipped, used ones read and checked,
//  and a repeating timer that fires is reloaded, since the single RAM port
//  and the shared adder serve one slot at a time. Reset clears all valid
//  bits and the high-water mark at once. A held result beat stalls the
//  sequencer only when it has a new beat.
`include "software_timer_slot_table_assert.svh"

module software_timer_slot_table
  import stt_pkg::*;
#(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  stt_cmd_if.sink cmd_i,
  stt_res_if.source res_o
);

  localparam int ID_W = $clog2(SLOTS + 1);
  localparam int AW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EW   = $bits(slot_info_t) + TIME_BITS;
  localparam int CW   = (TIME_BITS > 31) ? TIME_BITS : 31;

  // Sequencer state codes.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SET  = 3'd1;
  localparam logic [2:0] S_KILL = 3'd2;
  localparam logic [2:0] S_PRD  = 3'd3;
  localparam logic [2:0] S_PEV  = 3'd4;
  localparam logic [2:0] S_PRL  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]           state_q, state_d;
  logic [ID_W-1:0]      idx_q, idx_d;
  logic [ID_W-1:0]      hw_q, hw_d;
  logic [SLOTS-1:0]     valid_q, valid_d;

  logic [TIME_BITS-1:0] now_q;
  logic [30:0]          period_q;
  logic                 rep_q;
  logic [3:0]           owner_q;
  logic [7:0]           handler_q;
  logic [31:0]          tag_q;
  logic [ID_W-1:0]      id_q;

  logic                 accept;
  logic [AW-1:0]        idx_a;
  logic [ID_W-1:0]      kill_m1;
  logic [AW-1:0]        kill_a;
  logic                 at_end, hw_full, kill_bad, fire_hit;

  logic                 ram_we, ram_re, wsel_set;
  logic [EW-1:0]        ram_wdata, ram_rdata;
  slot_info_t           rd_info, set_info;
  logic [TIME_BITS-1:0] rd_start;

  alu_op_e              alu_op;
  logic [TIME_BITS-1:0] alu_a, alu_b, alu_y;

  logic                 push, push_ok;
  res_t                 res;
  logic [ID_W-1:0]      res_id;
  logic                 fire_push, set_push;

  assign cmd_i.ready = (state_q == S_IDLE);
  assign accept      = cmd_i.valid && cmd_i.ready;

  // Command capture.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q     <= TIME_BITS'(cmd_i.now_time);
      period_q  <= cmd_i.period;
      rep_q     <= cmd_i.repeating;
      owner_q   <= cmd_i.owner_id;
      handler_q <= cmd_i.handler_id;
      tag_q     <= cmd_i.user_tag;
      id_q      <= cmd_i.slot_id;
    end
  end

  // Slot decode.
  assign idx_a    = idx_q[AW-1:0];
  assign kill_m1  = id_q - ID_W'(1);
  assign kill_a   = kill_m1[AW-1:0];
  assign at_end   = (idx_q == hw_q);
  assign hw_full  = (hw_q == ID_W'(SLOTS));
  assign kill_bad = (id_q == '0) || (id_q > hw_q) || !valid_q[kill_a];

  // Slot RAM word: static fields on top, start time below.
  assign rd_info  = slot_info_t'(ram_rdata[EW-1:TIME_BITS]);
  assign rd_start = ram_rdata[TIME_BITS-1:0];

  always_comb begin
    set_info.period  = period_q;
    set_info.rep     = rep_q;
    set_info.owner   = owner_q;
    set_info.handler = handler_q;
    set_info.tag     = tag_q;
  end

  assign ram_wdata = wsel_set ? {set_info, now_q} : {rd_info, alu_y};

  stt_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_a),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_a),
    .rdata_o (ram_rdata)
  );

  // Shared adder: elapsed time while checking, new start while reloading.
  assign alu_op = (state_q == S_PRL) ? ALU_ADD : ALU_SUB;
  assign alu_a  = (state_q == S_PRL) ? rd_start : now_q;
  assign alu_b  = (state_q == S_PRL) ? TIME_BITS'(rd_info.period) : rd_start;

  stt_alu #(
    .W (TIME_BITS)
  ) u_alu (
    .op_i (alu_op),
    .a_i  (alu_a),
    .b_i  (alu_b),
    .y_o  (alu_y)
  );

  assign fire_hit = (rd_info.owner == owner_q) &&
                    (CW'(alu_y) >= CW'(rd_info.period));

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    hw_d     = hw_q;
    valid_d  = valid_q;
    push     = 1'b0;
    res      = '0;
    res_id   = '0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    wsel_set = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        idx_d = '0;
        if (accept) begin
          unique case (cmd_i.cmd)
            CMD_SET:  state_d = S_SET;
            CMD_KILL: state_d = S_KILL;
            CMD_PROC: state_d = S_PRD;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_SET: begin
        res.kind = KIND_SET;
        res.last = 1'b1;
        priority if (at_end && hw_full) begin
          res.status = ST_FULL;
          if (push_ok) begin
            push    = 1'b1;
            state_d = S_IDLE;
          end
        end else if (at_end || !valid_q[idx_a]) begin
          res.status = ST_OK;
          res_id     = idx_q + ID_W'(1);
          if (push_ok) begin
            push           = 1'b1;
            ram_we         = 1'b1;
            wsel_set       = 1'b1;
            valid_d[idx_a] = 1'b1;
            if (at_end) begin
              hw_d = hw_q + ID_W'(1);
            end
            state_d = S_IDLE;
          end
        end else begin
          idx_d = idx_q + ID_W'(1);
        end
      end
      S_KILL: begin
        res.kind   = KIND_KILL;
        res.status = kill_bad ? ST_BAD_ID : ST_OK;
        res.last   = 1'b1;
        if (push_ok) begin
          push = 1'b1;
          if (!kill_bad) begin
            valid_d[kill_a] = 1'b0;
          end
          state_d = S_IDLE;
        end
      end
      S_PRD: begin
        priority if (at_end) begin
          state_d = S_DONE;
        end else if (!valid_q[idx_a]) begin
          idx_d = idx_q + ID_W'(1);
        end else begin
          ram_re  = 1'b1;
          state_d = S_PEV;
        end
      end
      S_PEV: begin
        res.kind    = KIND_FIRE;
        res.status  = ST_OK;
        res.handler = rd_info.handler;
        res.tag     = rd_info.tag;
        res_id      = idx_q + ID_W'(1);
        if (!fire_hit) begin
          idx_d   = idx_q + ID_W'(1);
          state_d = S_PRD;
        end else if (push_ok) begin
          push = 1'b1;
          if (rd_info.rep) begin
            state_d = S_PRL;
          end else begin
            valid_d[idx_a] = 1'b0;
            idx_d          = idx_q + ID_W'(1);
            state_d        = S_PRD;
          end
        end
      end
      S_PRL: begin
        ram_we  = 1'b1;
        idx_d   = idx_q + ID_W'(1);
        state_d = S_PRD;
      end
      S_DONE: begin
        res.kind = KIND_DONE;
        res.last = 1'b1;
        if (push_ok) begin
          push    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      hw_q    <= '0;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      hw_q    <= hw_d;
      valid_q <= valid_d;
    end
  end

  stt_out_reg #(
    .ID_W (ID_W)
  ) u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .res_i     (res),
    .id_i      (res_id),
    .push_ok_o (push_ok),
    .res_o     (res_o)
  );

  // Beats that the checks below look at.
  assign fire_push = push && (res.kind == KIND_FIRE);
  assign set_push  = push && (state_q == S_SET) && (res.status == ST_OK);

  // The high-water mark only grows and never passes the table size.
  `STT_ASSERT_NEXT(a_hw_grows, clk_i, rst_ni, 1'b1, hw_q >= $past(hw_q), "high-water mark shrank")
  `STT_ASSERT_IMPLY(a_hw_bound, clk_i, rst_ni, 1'b1, hw_q <= ID_W'(SLOTS), "mark overflowed")

  // A fire beat is only issued for a slot that is in use.
  `STT_ASSERT_IMPLY(a_fire_valid, clk_i, rst_ni, fire_push, valid_q[idx_a], "fire on free slot")

  // A successful set leaves its slot marked in use.
  `STT_ASSERT_NEXT(a_set_marks, clk_i, rst_ni, set_push, valid_q[$past(idx_a)], "set slot left free")

endmodule
